>>> rtl/core/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min/max contrast stretch block:
// controller states, controller-to-datapath commands and register map.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  // Default pixel width
  localparam int unsigned PIXEL_BITS_DEF = 8;

  // Width of the intensity register and of the rescaled pixel
  localparam int unsigned INT_W = 8;

  // Quotient bits produced by the divider, one per step
  localparam int unsigned DIV_STEPS = INT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Register map
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_MAX_INTENSITY = 1'b0;
  localparam logic [INT_W-1:0] MAX_INTENSITY_RST = 8'd255;

  // Input mode codes
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_APPLY   = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic measure;   // fold the input pixel into min/max
    logic capture;   // latch operands of an apply item
    logic load_div;  // multiply and seed the divider
    logic div_step;  // one restoring division step
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic bypass;    // result is settled without division
  } status_t;

endpackage

>>> rtl/core/min_max_contrast_stretch.sv
// A measure item gives no result; an apply item is settled by range checks, or
// goes through 1 multiply, 8 divider steps and 1 hand-off to the output register.
// An apply item holds off new items until its result is in the output register,
// which waits while the receiver stalls. Measure items: one per cycle while idle;
// the radix-2 divider gives one quotient bit per cycle.
// Reset: asynchronous, active low; min is all ones, max 0, max_intensity 255.
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Two-pass linear contrast stretch of grey pixels with an APB-style register
// port for the output intensity ceiling.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch
  import mmcs_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB-style register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  // Input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  input  logic                  start_frame_i,
  // Result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [INT_W-1:0]      pixel_out_o
);

  logic [INT_W-1:0] max_intensity_q;
  logic             reg_hit;
  cmd_t             cmd;
  status_t          status;

  // Register write and read-back
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_MAX_INTENSITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_intensity_q <= MAX_INTENSITY_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_intensity_q <= pwdata[INT_W-1:0];
    end
  end

  assign prdata = reg_hit ? PDATA_W'(max_intensity_q) : '0;

  mmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmcs_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .pixel_i         (pixel_i),
    .start_frame_i   (start_frame_i),
    .max_intensity_i (max_intensity_q),
    .pixel_out_o     (pixel_out_o)
  );

endmodule

>>> rtl/core/mmcs_ctrl.sv
// ----------------------------------------------------------------------------
// mmcs_ctrl
// Controller for the contrast stretch: takes items, sequences the multiply
// and the eight-step divide, and owns the output valid flag.
// ----------------------------------------------------------------------------
module mmcs_ctrl
  import mmcs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    mode_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_acc;
  logic                 out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i == MODE_MEASURE) begin
            cmd_o.measure = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d = status_i.bypass ? ST_DONE : ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load_div = 1'b1;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/mmcs_dp.sv
// ----------------------------------------------------------------------------
// mmcs_dp
// Datapath for the contrast stretch: running min/max, operand capture,
// one multiplier and a radix-2 restoring divider, output register.
// ----------------------------------------------------------------------------
module mmcs_dp
  import mmcs_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  input  logic                  start_frame_i,
  input  logic [INT_W-1:0]      max_intensity_i,
  output logic [INT_W-1:0]      pixel_out_o
);

  localparam int unsigned PROD_W = PIXEL_BITS + INT_W;
  localparam logic [INT_W-1:0] OUT_MASK =
    (PIXEL_BITS >= INT_W) ? {INT_W{1'b1}} : INT_W'((1 << PIXEL_BITS) - 1);

  logic [PIXEL_BITS-1:0] min_q, min_d;
  logic [PIXEL_BITS-1:0] max_q, max_d;
  logic [PIXEL_BITS-1:0] diff_q, span_q;
  logic [PIXEL_BITS-1:0] rem_q;
  logic [INT_W-1:0]      low_q;
  logic [INT_W-1:0]      pixel_out_q;
  logic [INT_W-1:0]      bypass_val;
  logic [PROD_W-1:0]     prod;
  logic [PIXEL_BITS:0]   trial;
  logic [PIXEL_BITS:0]   trial_sub;
  logic                  trial_ge;

  // Settle flat ranges and pixels at or beyond the range ends without dividing
  always_comb begin
    status_o.bypass = 1'b0;
    bypass_val      = '0;
    if (max_q <= min_q || pixel_i <= min_q) begin
      status_o.bypass = 1'b1;
    end else if (pixel_i >= max_q) begin
      status_o.bypass = 1'b1;
      bypass_val      = max_intensity_i;
    end
  end

  // Running min/max update
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (cmd_i.measure) begin
      if (start_frame_i) begin
        min_d = pixel_i;
        max_d = pixel_i;
      end else begin
        if (pixel_i < min_q) min_d = pixel_i;
        if (pixel_i > max_q) max_d = pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= {PIXEL_BITS{1'b1}};
      max_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Product and one division step
  assign prod      = PROD_W'(diff_q) * PROD_W'(max_intensity_i);
  assign trial     = {rem_q, low_q[INT_W-1]};
  assign trial_ge  = (trial >= {1'b0, span_q});
  assign trial_sub = trial - {1'b0, span_q};

  // Operands, divider and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      diff_q <= pixel_i - min_q;
      span_q <= max_q - min_q;
      low_q  <= bypass_val;
    end
    if (cmd_i.load_div) begin
      // Upper part of the product is below the span, so eight steps suffice
      rem_q <= prod[PROD_W-1:INT_W];
      low_q <= prod[INT_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
      low_q <= {low_q[INT_W-2:0], trial_ge};
    end
    if (cmd_i.out_load) begin
      pixel_out_q <= low_q & OUT_MASK;
    end
  end

  assign pixel_out_o = pixel_out_q;

endmodule

>>> tb/tb_min_max_contrast_stretch.sv
// ----------------------------------------------------------------------------
// tb_min_max_contrast_stretch
// Self-checking bench for the two-pass contrast stretch. Frames are measured
// and then replayed in apply mode, with noise items mixed in. A local
// predictor tracks min/max and the intensity ceiling and queues every
// rescaled pixel. Results are checked in order. The ceiling is swept over
// several values between phases through the register port.
// ----------------------------------------------------------------------------
module tb_min_max_contrast_stretch;
  import mmcs_pkg::*;

  localparam int unsigned PIX_W      = PIXEL_BITS_DEF;
  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned SETTLE     = 16;
  localparam int unsigned PHASE_ITEMS = 55;
  localparam int unsigned LONG_HOLD  = 300;

  typedef struct {
    logic             mode;
    logic [PIX_W-1:0] pixel;
    logic             start;
  } pixel_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Register port
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Item channels
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_mode = MODE_MEASURE;
  logic [PIX_W-1:0] in_pixel = '0;
  logic             in_start = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [INT_W-1:0] pixel_out;

  // Predictor state
  logic [PIX_W-1:0] frame_min = '1;
  logic [PIX_W-1:0] frame_max = '0;
  logic [INT_W-1:0] ceiling = MAX_INTENSITY_RST;

  pixel_item_t      pixel_items_q[$];
  logic [INT_W-1:0] stretched_q[$];

  logic in_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 4;
  int   errors = 0;
  int   items_taken = 0;
  int   results_checked = 0;
  int   ceiling_writes = 0;
  int   cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   stall_style = 0;
  int   style_left = 0;

  min_max_contrast_stretch DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (in_mode),
    .pixel_i      (in_pixel),
    .start_frame_i(in_start),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_out_o  (pixel_out)
  );

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Map a pixel through the current min/max range, saturating at the ceiling
  function automatic logic [INT_W-1:0] stretch_pixel(logic [PIX_W-1:0] p);
    logic [15:0] scaled;
    logic [15:0] quot;
    if (frame_max <= frame_min) return '0;
    if (p <= frame_min) return '0;
    if (p >= frame_max) return ceiling;
    scaled = 16'(p - frame_min) * 16'(ceiling);
    quot = scaled / 16'(frame_max - frame_min);
    if (quot > 16'(ceiling)) quot = 16'(ceiling);
    return quot[INT_W-1:0];
  endfunction

  // Check results first, then fold accepted items into the predictor
  always @(posedge clk_i) begin : track
    logic [INT_W-1:0] want;
    in_taken <= in_valid && in_ready;
    if (rst_ni && out_valid && out_ready) begin
      results_checked++;
      if (stretched_q.size() == 0) begin
        $error("unexpected result: pixel_out actual %0d", pixel_out);
        errors++;
      end else begin
        want = stretched_q.pop_front();
        if (pixel_out !== want) begin
          $error("pixel_out: expected %0d, actual %0d", want, pixel_out);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid && in_ready) begin
      items_taken++;
      if (in_mode == MODE_MEASURE) begin
        if (in_start) begin
          frame_min = in_pixel;
          frame_max = in_pixel;
        end else begin
          if (in_pixel < frame_min) frame_min = in_pixel;
          if (in_pixel > frame_max) frame_max = in_pixel;
        end
      end else begin
        stretched_q.insert(stretched_q.size(), stretch_pixel(in_pixel));
      end
    end
  end

  // Drive items in bursts with random gaps; hold each item until taken
  always @(negedge clk_i) begin : drive
    pixel_item_t cur;
    if (rst_ni && (!in_valid || in_taken)) begin
      if (gap_left != 0 || pixel_items_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        cur = pixel_items_q.pop_front();
        in_valid <= 1'b1;
        in_mode  <= cur.mode;
        in_pixel <= cur.pixel;
        in_start <= cur.start;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver stalls on a changing pattern, with one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_checked >= 60) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(20, 120);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cycles % 4) != 0;
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("min_max_contrast_stretch: mismatch");
      $finish;
    end
  end

  task automatic queue_item(logic mode, logic [PIX_W-1:0] pixel, logic start);
    pixel_item_t it;
    it.mode  = mode;
    it.pixel = pixel;
    it.start = start;
    pixel_items_q.insert(pixel_items_q.size(), it);
  endtask

  // Wait for the block to drain, then let it settle
  task automatic wait_idle();
    while (pixel_items_q.size() != 0 || in_valid || stretched_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the ceiling, then read it back
  task automatic set_ceiling(logic [INT_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = PADDR_W'(REG_MAX_INTENSITY) << 2;
    pwdata = PDATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    ceiling = value;
    ceiling_writes++;
    psel = 1'b1; pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwdata = '0;
    if (rd[INT_W-1:0] !== value) begin
      $error("max_intensity: expected %0d, actual %0d", value, rd[INT_W-1:0]);
      errors++;
    end
  endtask

  // Measure a short frame, then replay it in apply mode
  task automatic queue_frame(output int added);
    logic [PIX_W-1:0] pix[16];
    int len;
    int style;
    int base;
    len = $urandom_range(2, 12);
    style = $urandom_range(0, 3);
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: pix[i] = PIX_W'($urandom_range(0, 255));
        1: pix[i] = PIX_W'((base + $urandom_range(0, 8)) % 256);
        2: pix[i] = PIX_W'(base);
        default: pix[i] = ($urandom_range(0, 1) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                     : PIX_W'($urandom_range(0, 255));
      endcase
      queue_item(MODE_MEASURE, pix[i], i == 0);
    end
    for (int i = 0; i < len; i++)
      queue_item(MODE_APPLY, pix[i], $urandom_range(0, 3) == 0);
    added = 2 * len;
    // Sometimes add a random probe, which may fall outside the measured range
    if ($urandom_range(0, 1) == 0) begin
      queue_item(MODE_APPLY, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      added++;
    end
  endtask

  task automatic queue_noise(output int added);
    added = $urandom_range(1, 6);
    for (int i = 0; i < added; i++)
      queue_item(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_phase();
    int total;
    int n;
    total = 0;
    while (total < PHASE_ITEMS) begin
      if ($urandom_range(0, 4) == 0) queue_noise(n);
      else queue_frame(n);
      total += n;
    end
  endtask

  initial begin : stimulus
    logic [INT_W-1:0] sweep[6];
    sweep[0] = 8'd0;
    sweep[1] = 8'd255;
    sweep[2] = 8'd1;
    sweep[3] = 8'd128;
    sweep[4] = INT_W'($urandom_range(2, 254));
    sweep[5] = INT_W'($urandom_range(0, 255));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Apply before any measurement: empty range, start flag ignored
    queue_item(MODE_APPLY, 8'd0, 1'b0);
    queue_item(MODE_APPLY, 8'd255, 1'b1);
    // Flat frame
    queue_item(MODE_MEASURE, 8'd100, 1'b1);
    queue_item(MODE_MEASURE, 8'd100, 1'b0);
    queue_item(MODE_APPLY, 8'd100, 1'b0);
    // Range 50..200: below, at and above the ends, and inside
    queue_item(MODE_MEASURE, 8'd50, 1'b0);
    queue_item(MODE_MEASURE, 8'd200, 1'b0);
    queue_item(MODE_APPLY, 8'd0, 1'b0);
    queue_item(MODE_APPLY, 8'd50, 1'b0);
    queue_item(MODE_APPLY, 8'd51, 1'b0);
    queue_item(MODE_APPLY, 8'd125, 1'b0);
    queue_item(MODE_APPLY, 8'd137, 1'b1);
    queue_item(MODE_APPLY, 8'd199, 1'b0);
    queue_item(MODE_APPLY, 8'd200, 1'b0);
    queue_item(MODE_APPLY, 8'd255, 1'b0);
    // Full range restarted from zero
    queue_item(MODE_MEASURE, 8'd0, 1'b1);
    queue_item(MODE_MEASURE, 8'd255, 1'b0);
    queue_item(MODE_APPLY, 8'd1, 1'b0);
    queue_item(MODE_APPLY, 8'd128, 1'b0);
    queue_item(MODE_APPLY, 8'd254, 1'b0);
    queue_item(MODE_APPLY, 8'd255, 1'b0);
    wait_idle();

    // Sweep the ceiling, one random phase per setting
    foreach (sweep[i]) begin
      set_ceiling(sweep[i]);
      queue_phase();
      wait_idle();
    end

    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d items and %0d checked results over %0d ceiling settings,",
             items_taken, results_checked, ceiling_writes + 1);
    $display("including flat, empty and saturating ranges and a long receiver stall.");
    if (errors == 0 && stretched_q.size() == 0) begin
      $display("min_max_contrast_stretch: match");
    end else begin
      $display("min_max_contrast_stretch: mismatch");
    end
    $finish;
  end

endmodule
